FILE: hdl/imh_pkg.sv
// Shared types and constants for the indexed min-heap.
// No dependencies.
package imh_pkg;

	typedef logic [1:0]  action_t;
	typedef logic [30:0] key_t;

	localparam action_t ACT_INIT  = 2'd0;
	localparam action_t ACT_DECR  = 2'd1;
	localparam action_t ACT_XMIN  = 2'd2;
	localparam action_t ACT_QUERY = 2'd3;

	localparam key_t KEY_MAX = '1;

	localparam int ENTRY_W = 8;
	localparam int COUNT_W = 9;

endpackage

FILE: hdl/indexed_min_heap.sv
// Indexed binary min-heap, top level: slot memory (entry, key), entry-to-slot memory.
// Depends on imh_pkg.
// Decrease key sifts up and extract sifts down through the heap levels; init reruns the
// clearing pass.
// Flow: one beat at a time; the next beat is taken once the result is registered.
// Reset: a clearing pass over all HEAP_ENTRIES slots loads identity order, max keys; in_stall high.
module indexed_min_heap
	import imh_pkg::*;
#(
	parameter int HEAP_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  action_t            action,
	input  logic [ENTRY_W-1:0] entry_id,
	input  key_t               new_key,
	input  logic [COUNT_W-1:0] load_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ENTRY_W-1:0] min_entry,
	output key_t               min_key,
	output logic               was_empty,
	output logic               is_member,
	output logic               rejected,
	output logic [COUNT_W-1:0] entries_left
);

	localparam int SW  = $clog2(HEAP_ENTRIES);
	localparam int CW  = $clog2(HEAP_ENTRIES + 1);
	localparam int CHW = SW + 2;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_UP    = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;
	localparam logic [2:0] ST_XRD   = 3'd5;
	localparam logic [2:0] ST_DN    = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	// memories
	logic [SW-1:0] ent_mem [HEAP_ENTRIES];
	key_t          key_mem [HEAP_ENTRIES];
	logic [SW-1:0] pos_mem [HEAP_ENTRIES];

	logic [SW-1:0] ent_a_q, ent_b_q, es_rd_q;
	key_t          key_a_q, key_b_q;

	logic          sl_we, es_we;
	logic [SW-1:0] sl_wa, sl_went, es_wa, es_wd;
	key_t          sl_wkey;
	logic [SW-1:0] ra, rb, es_ra;

	// control
	logic [2:0]    state_q;
	action_t       op_q;
	logic [SW-1:0] pos_q, mv_ent_q, clr_q;
	key_t          mv_key_q;
	logic          init_q;
	logic [CW-1:0] count_q;

	logic [ENTRY_W-1:0] res_ent_q;
	key_t               res_key_q;
	logic               res_empty_q, res_member_q, res_rej_q;

	logic [ENTRY_W-1:0] out_ent_q;
	key_t               out_key_q;
	logic               out_empty_q, out_member_q, out_rej_q, out_valid_q;
	logic [COUNT_W-1:0] out_left_q;

	logic           accept;
	logic           id_bad;
	logic [SW-1:0]  last_pos, par_w, gpar_w, lk_par;
	logic [CHW-1:0] cnt_w, lft_w, rgt_w, lft_nx, rgt_nx;
	logic           l_ok, r_ok, take_l, take_r, dn_move, up_swap, member;
	key_t           cmp_key;
	logic [SW-1:0]  best_pos, ch_ent;
	key_t           ch_key;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign id_bad   = 32'(entry_id) >= 32'(HEAP_ENTRIES);

	assign cnt_w    = CHW'(count_q);
	assign last_pos = SW'(count_q - CW'(1));
	assign lk_par   = (es_rd_q - SW'(1)) >> 1;
	assign par_w    = (pos_q - SW'(1)) >> 1;
	assign gpar_w   = (par_w - SW'(1)) >> 1;
	assign member   = {2'b00, es_rd_q} < cnt_w;
	assign up_swap  = mv_key_q < key_a_q;

	assign lft_w    = {1'b0, pos_q, 1'b1};
	assign rgt_w    = {1'b0, pos_q, 1'b0} + CHW'(2);
	assign l_ok     = lft_w < cnt_w;
	assign r_ok     = rgt_w < cnt_w;
	assign take_l   = l_ok && (key_a_q < mv_key_q);
	assign cmp_key  = take_l ? key_a_q : mv_key_q;
	assign take_r   = r_ok && (key_b_q < cmp_key);
	assign dn_move  = take_l || take_r;
	assign best_pos = take_r ? SW'(rgt_w) : SW'(lft_w);
	assign ch_ent   = take_r ? ent_b_q : ent_a_q;
	assign ch_key   = take_r ? key_b_q : key_a_q;
	assign lft_nx   = {1'b0, best_pos, 1'b1};
	assign rgt_nx   = {1'b0, best_pos, 1'b0} + CHW'(2);

	always_comb begin
		sl_we   = 1'b0;
		sl_wa   = pos_q;
		sl_went = mv_ent_q;
		sl_wkey = mv_key_q;
		es_we   = 1'b0;
		es_wa   = mv_ent_q;
		es_wd   = pos_q;
		ra      = '0;
		rb      = last_pos;
		es_ra   = SW'(entry_id);
		unique case (state_q)
			ST_CLEAR: begin
				sl_we   = 1'b1;
				sl_wa   = clr_q;
				sl_went = clr_q;
				sl_wkey = KEY_MAX;
				es_we   = 1'b1;
				es_wa   = clr_q;
				es_wd   = clr_q;
			end
			ST_IDLE: begin
			end
			ST_LOOK: begin
				ra = lk_par;
			end
			ST_UP: begin
				ra = gpar_w;
				if (up_swap) begin
					sl_we   = 1'b1;
					sl_went = ent_a_q;
					sl_wkey = key_a_q;
					es_we   = 1'b1;
					es_wa   = ent_a_q;
				end
			end
			ST_PUT: begin
				sl_we = 1'b1;
				es_we = 1'b1;
			end
			ST_XRD: begin
				ra      = SW'(1);
				rb      = SW'(2);
				sl_we   = 1'b1;
				sl_wa   = last_pos;
				sl_went = ent_a_q;
				sl_wkey = key_a_q;
				es_we   = 1'b1;
				es_wa   = ent_a_q;
				es_wd   = last_pos;
			end
			ST_DN: begin
				ra = SW'(lft_nx);
				rb = SW'(rgt_nx);
				if (dn_move) begin
					sl_we   = 1'b1;
					sl_went = ch_ent;
					sl_wkey = ch_key;
					es_we   = 1'b1;
					es_wa   = ch_ent;
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			ent_mem[sl_wa] <= sl_went;
			key_mem[sl_wa] <= sl_wkey;
		end
		if (es_we) begin
			pos_mem[es_wa] <= es_wd;
		end
		ent_a_q <= ent_mem[ra];
		key_a_q <= key_mem[ra];
		ent_b_q <= ent_mem[rb];
		key_b_q <= key_mem[rb];
		es_rd_q <= pos_mem[es_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			op_q         <= ACT_INIT;
			pos_q        <= '0;
			mv_ent_q     <= '0;
			mv_key_q     <= '0;
			clr_q        <= '0;
			init_q       <= 1'b0;
			count_q      <= '0;
			res_ent_q    <= '0;
			res_key_q    <= '0;
			res_empty_q  <= 1'b0;
			res_member_q <= 1'b0;
			res_rej_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(HEAP_ENTRIES - 1)) begin
						state_q <= init_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q         <= action;
						mv_ent_q     <= SW'(entry_id);
						mv_key_q     <= new_key;
						res_ent_q    <= '0;
						res_key_q    <= '0;
						res_empty_q  <= 1'b0;
						res_member_q <= 1'b0;
						res_rej_q    <= 1'b0;
						case (action)
							ACT_INIT: begin
								if (32'(load_count) > 32'(HEAP_ENTRIES)) begin
									count_q <= CW'(HEAP_ENTRIES);
								end else begin
									count_q <= CW'(load_count);
								end
								clr_q   <= '0;
								init_q  <= 1'b1;
								state_q <= ST_CLEAR;
							end
							ACT_XMIN: begin
								if (count_q == '0) begin
									res_empty_q <= 1'b1;
									state_q     <= ST_FIN;
								end else begin
									state_q <= ST_XRD;
								end
							end
							default: begin
								if (id_bad) begin
									res_rej_q <= (action == ACT_DECR);
									state_q   <= ST_FIN;
								end else begin
									state_q <= ST_LOOK;
								end
							end
						endcase
					end
				end
				ST_LOOK: begin
					pos_q <= es_rd_q;
					if (op_q == ACT_QUERY) begin
						res_member_q <= member;
						state_q      <= ST_FIN;
					end else if (!member) begin
						res_rej_q <= 1'b1;
						state_q   <= ST_FIN;
					end else if (es_rd_q == '0) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_UP;
					end
				end
				ST_UP: begin
					if (up_swap) begin
						pos_q <= par_w;
						if (par_w == '0) begin
							state_q <= ST_PUT;
						end
					end else begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					state_q <= ST_FIN;
				end
				ST_XRD: begin
					res_ent_q <= ENTRY_W'(ent_a_q);
					res_key_q <= key_a_q;
					count_q   <= count_q - CW'(1);
					mv_ent_q  <= ent_b_q;
					mv_key_q  <= key_b_q;
					pos_q     <= '0;
					state_q   <= ST_DN;
				end
				ST_DN: begin
					if (dn_move) begin
						pos_q <= best_pos;
					end else begin
						state_q <= ST_PUT;
					end
				end
				ST_FIN: begin
					init_q <= 1'b0;
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat payload, held while stalled
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
			out_ent_q    <= res_ent_q;
			out_key_q    <= res_key_q;
			out_empty_q  <= res_empty_q;
			out_member_q <= res_member_q;
			out_rej_q    <= res_rej_q;
			out_left_q   <= COUNT_W'(count_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign min_entry    = out_ent_q;
	assign min_key      = out_key_q;
	assign was_empty    = out_empty_q;
	assign is_member    = out_member_q;
	assign rejected     = out_rej_q;
	assign entries_left = out_left_q;

endmodule

FILE: tb/tb_indexed_min_heap.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_min_heap: a heap predictor kept in step with accepted beats.
// Depends on imh_pkg and the indexed_min_heap RTL.
module tb_indexed_min_heap;
	import imh_pkg::*;

	localparam int HEAP_N    = 256;
	localparam int STALL_MAX = 4000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		action_t            act;
		logic [ENTRY_W-1:0] id;
		key_t               key;
		logic [COUNT_W-1:0] cnt;
	} heap_op_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] ent;
		key_t               key;
		logic               empty;
		logic               member;
		logic               rej;
		logic [COUNT_W-1:0] left;
	} heap_res_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	action_t            action     = ACT_QUERY;
	logic [ENTRY_W-1:0] entry_id   = '0;
	key_t               new_key    = '0;
	logic [COUNT_W-1:0] load_count = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [ENTRY_W-1:0] min_entry;
	key_t               min_key;
	logic               was_empty;
	logic               is_member;
	logic               rejected;
	logic [COUNT_W-1:0] entries_left;

	heap_op_t  op_queue[$];
	heap_res_t heap_results_due[$];
	logic      in_taken = 1'b0;
	int        send_idle_pct = 9;
	int        recv_idle_pct = 63;
	int        errors = 0;
	int        quiet_cycles = 0;

	logic [ENTRY_W-1:0] mdl_ent [0:HEAP_N-1];
	key_t               mdl_key [0:HEAP_N-1];
	logic [ENTRY_W-1:0] mdl_pos [0:HEAP_N-1];
	logic [COUNT_W-1:0] mdl_count;

	indexed_min_heap #(
		.HEAP_ENTRIES(HEAP_N)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.entry_id    (entry_id),
		.new_key     (new_key),
		.load_count  (load_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.min_entry   (min_entry),
		.min_key     (min_key),
		.was_empty   (was_empty),
		.is_member   (is_member),
		.rejected    (rejected),
		.entries_left(entries_left)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void mdl_load_identity();
		for (int i = 0; i < HEAP_N; i++) begin
			mdl_ent[i] = ENTRY_W'(i);
			mdl_key[i] = KEY_MAX;
			mdl_pos[i] = ENTRY_W'(i);
		end
	endfunction

	function automatic void mdl_swap(int a, int b);
		logic [ENTRY_W-1:0] ea, eb;
		key_t               k;
		ea = mdl_ent[a];
		eb = mdl_ent[b];
		k = mdl_key[a];
		mdl_ent[a] = eb;
		mdl_ent[b] = ea;
		mdl_key[a] = mdl_key[b];
		mdl_key[b] = k;
		mdl_pos[eb] = ENTRY_W'(a);
		mdl_pos[ea] = ENTRY_W'(b);
	endfunction

	function automatic heap_res_t heap_apply(heap_op_t op);
		heap_res_t r;
		int        p, up, best, l, rt;
		r = '0;
		case (op.act)
			ACT_INIT: begin
				mdl_load_identity();
				mdl_count = (op.cnt > HEAP_N) ? COUNT_W'(HEAP_N) : op.cnt;
			end
			ACT_DECR: begin
				if (mdl_pos[op.id] < mdl_count) begin
					p = int'(mdl_pos[op.id]);
					mdl_key[p] = op.key;
					while (p != 0) begin
						up = (p - 1) / 2;
						if (!(mdl_key[p] < mdl_key[up]))
							break;
						mdl_swap(p, up);
						p = up;
					end
				end else begin
					r.rej = 1'b1;
				end
			end
			ACT_XMIN: begin
				if (mdl_count == 0) begin
					r.empty = 1'b1;
				end else begin
					r.ent = mdl_ent[0];
					r.key = mdl_key[0];
					mdl_count = mdl_count - 1'b1;
					mdl_swap(0, int'(mdl_count));
					p = 0;
					forever begin
						best = p;
						l = 2 * p + 1;
						rt = 2 * p + 2;
						if (l < mdl_count && mdl_key[l] < mdl_key[best])
							best = l;
						if (rt < mdl_count && mdl_key[rt] < mdl_key[best])
							best = rt;
						if (best == p)
							break;
						mdl_swap(p, best);
						p = best;
					end
				end
			end
			default: begin
				r.member = (mdl_pos[op.id] < mdl_count);
			end
		endcase
		r.left = mdl_count;
		return r;
	endfunction

	// driver: a stalled beat holds, otherwise the next op goes out unless the sender idles
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		if (arst_n && (!in_valid || in_taken)) begin
			if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				heap_op_t op;
				op = op_queue.pop_front();
				in_valid   <= 1'b1;
				action     <= op.act;
				entry_id   <= op.id;
				new_key    <= op.key;
				load_count <= op.cnt;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check result beats, predict on input beats, watch for a hang
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			heap_res_t got, want;
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				got = '{min_entry, min_key, was_empty, is_member, rejected, entries_left};
				if (heap_results_due.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("unexpected result beat: entry %0d key %0d left %0d",
							got.ent, got.key, got.left);
				end else begin
					want = heap_results_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= MAX_SHOWN)
							$display({"mismatch: got entry %0d key %0d empty %0b member %0b ",
								"rej %0b left %0d; want entry %0d key %0d empty %0b ",
								"member %0b rej %0b left %0d"},
								got.ent, got.key, got.empty, got.member, got.rej, got.left,
								want.ent, want.key, want.empty, want.member, want.rej,
								want.left);
					end
				end
			end
			if (in_valid && !in_stall)
				heap_results_due.push_back(heap_apply('{action, entry_id, new_key, load_count}));
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("indexed_min_heap regression: fail");
				$finish;
			end
		end
	end

	task automatic push_op(action_t a, logic [ENTRY_W-1:0] id, key_t k, logic [COUNT_W-1:0] c);
		op_queue.push_back('{a, id, k, c});
	endtask

	task automatic wait_drained();
		while (op_queue.size() != 0 || in_valid || heap_results_due.size() != 0)
			@(posedge clk);
	endtask

	// runs of init then decrease/extract/query on that heap; a few noise beats between
	task automatic queue_random_ops(int n);
		int                 done, c, sz, run_len, sel;
		logic [ENTRY_W-1:0] id;
		key_t               k;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 99) < 8) begin
				push_op(action_t'($urandom_range(0, 3)), ENTRY_W'($urandom), key_t'($urandom),
					COUNT_W'($urandom));
				done++;
			end else begin
				c = ($urandom_range(0, 9) == 0) ? HEAP_N : $urandom_range(1, 24);
				push_op(ACT_INIT, ENTRY_W'($urandom), key_t'($urandom), COUNT_W'(c));
				sz = c;
				run_len = $urandom_range(4, 40);
				done++;
				for (int i = 0; i < run_len; i++) begin
					sel = $urandom_range(0, 99);
					case ($urandom_range(0, 3))
						0:       k = key_t'($urandom_range(0, 15));
						1:       k = key_t'($urandom_range(0, 1000));
						2:       k = key_t'($urandom);
						default: k = KEY_MAX - key_t'($urandom_range(0, 3));
					endcase
					id = ENTRY_W'($urandom_range(0, c - 1));
					if (sel < 45) begin
						push_op(ACT_DECR, id, k, COUNT_W'($urandom));
					end else if (sel < 80) begin
						push_op(ACT_XMIN, ENTRY_W'($urandom), k, COUNT_W'($urandom));
						if (sz > 0)
							sz--;
					end else if (sel < 95) begin
						push_op(ACT_QUERY, $urandom_range(0, 1) ? id : ENTRY_W'($urandom), k,
							COUNT_W'($urandom));
					end else begin
						push_op(ACT_DECR, ENTRY_W'($urandom), k, COUNT_W'($urandom));
					end
					done++;
				end
				// empty the heap and extract once more
				if ($urandom_range(0, 2) == 0) begin
					repeat (sz + 1)
						push_op(ACT_XMIN, ENTRY_W'($urandom), key_t'($urandom),
							COUNT_W'($urandom));
					done += sz + 1;
				end
			end
		end
	endtask

	initial begin
		mdl_load_identity();
		mdl_count = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_op(ACT_QUERY, 8'd0, '0, '0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_DECR, 8'd5, 31'd7, '0);
		push_op(ACT_INIT, 8'd0, '0, 9'd511);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_DECR, 8'd255, '0, '0);
		push_op(ACT_DECR, 8'd20, 31'd100, '0);
		push_op(ACT_DECR, 8'd20, 31'd2000, '0);
		push_op(ACT_DECR, 8'd10, KEY_MAX, '0);
		push_op(ACT_QUERY, 8'd0, '0, '0);
		push_op(ACT_QUERY, 8'd255, '0, '0);
		push_op(ACT_DECR, 8'd0, 31'd1, '0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_INIT, 8'd0, '0, 9'd257);
		push_op(ACT_INIT, 8'd0, '0, 9'd0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_QUERY, 8'd0, '0, '0);
		push_op(ACT_INIT, 8'd0, '0, 9'd1);
		push_op(ACT_DECR, 8'd0, KEY_MAX - 1'b1, '0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_XMIN, 8'd0, '0, '0);
		push_op(ACT_INIT, 8'd0, '0, 9'd2);
		push_op(ACT_DECR, 8'd1, '0, '0);
		queue_random_ops(500);
		wait_drained();

		send_idle_pct = 63;
		recv_idle_pct = 9;
		queue_random_ops(520);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_ops(520);
		wait_drained();

		repeat (300) @(posedge clk);
		if (errors == 0 && heap_results_due.size() == 0)
			$display("indexed_min_heap regression: pass");
		else
			$display("indexed_min_heap regression: fail");
		$finish;
	end

endmodule

FILE: files.f
hdl/imh_pkg.sv
hdl/indexed_min_heap.sv
tb/tb_indexed_min_heap.sv
